// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/lmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lmt_pkg
// types, constants and helpers for the lcd timing and line fetch block
// ----------------------------------------------------------------------------
`default_nettype none
package lmt_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [8:0] HBLANK_CLOCKS = 9'd204;
    localparam logic [8:0] VBLANK_CLOCKS = 9'd456;
    localparam logic [8:0] OAM_CLOCKS    = 9'd80;
    localparam logic [8:0] XFER_CLOCKS   = 9'd172;
    localparam logic [8:0] TICK_CLOCKS   = 9'd4;
    localparam logic [7:0] LAST_VIS_LINE = 8'd143;
    localparam logic [7:0] LAST_LINE     = 8'd153;
    // top three address bits of the tile map at offset 0x1800
    localparam logic [2:0] MAP_BASE_HI   = 3'b110;
    localparam logic [4:0] LAST_COLUMN   = 5'd31;

    localparam logic       CFG_SCROLL_Y = 1'b0;
    localparam logic       CFG_SCROLL_X = 1'b1;

    localparam logic       IN_TICK  = 1'b0;
    localparam logic       IN_WRITE = 1'b1;
    localparam logic       OUT_LINE = 1'b0;
    localparam logic       OUT_PIX  = 1'b1;

    typedef enum logic [1:0] {
        M_HBLANK = 2'd0,
        M_VBLANK = 2'd1,
        M_OAM    = 2'd2,
        M_XFER   = 2'd3
    } t_lcd_mode;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_FETCH = 2'd2
    } t_cmd_kind;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_MAP  = 3'd1,
        B_TILE = 3'd2,
        B_LO   = 3'd3,
        B_HI   = 3'd4
    } t_bstate;

    typedef struct packed {
        logic                mode;
        logic [VRAM_AW-1:0]  vram_address;
        logic [7:0]          vram_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  line_counter;
        logic [4:0]  tile_column;
        logic [7:0]  background_row;
        logic [63:0] shades;
        logic        last;
    } t_out;

    // work command from the front to the back
    typedef struct packed {
        t_cmd_kind           kind;
        logic [VRAM_AW-1:0]  addr;
        logic [7:0]          data;
        logic [4:0]          col;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    // two bitplane bytes to eight shades, leftmost pixel in the top byte
    function automatic logic [63:0] to_shades(input logic [7:0] lo, input logic [7:0] hi);
        logic [63:0] res;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            case ({hi[b], lo[b]})
                2'd0:    res[b*8 +: 8] = 8'd255;
                2'd1:    res[b*8 +: 8] = 8'd192;
                2'd2:    res[b*8 +: 8] = 8'd96;
                default: res[b*8 +: 8] = 8'd0;
            endcase
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/lmt_queue.sv =====
// ----------------------------------------------------------------------------
// lmt_queue
// short command fifo between the timing front and the fetch back
// ----------------------------------------------------------------------------
`default_nettype none
module lmt_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  lmt_pkg::t_cmd   i_push_cmd,
    output logic            o_full,
    input  wire             i_pop,
    output lmt_pkg::t_cmd   o_pop_cmd,
    output logic            o_empty
);
    import lmt_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full    = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ===== src/lmt_front.sv =====
// ----------------------------------------------------------------------------
// lmt_front
// accepts items, runs the lcd mode timing and issues commands to the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lmt_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  lmt_pkg::t_in         i_in,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire [7:0]            i_cfg_data,
    input  lmt_pkg::t_back_status i_bstat,
    input  wire                  i_q_full,
    output logic                 o_push,
    output lmt_pkg::t_cmd        o_cmd
);
    import lmt_pkg::*;

    t_lcd_mode  r_mode, n_mode;
    logic [8:0] r_clock, n_clock;
    logic [7:0] r_line, n_line;
    logic [7:0] r_scroll_y, r_scroll_x;
    logic       accept;
    logic [8:0] clk_add;
    logic [7:0] line_inc;

    assign o_ready  = !i_q_full && !i_bstat.clearing;
    assign accept   = i_valid && o_ready;
    assign clk_add  = r_clock + TICK_CLOCKS;
    assign line_inc = r_line + 8'd1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_y <= '0;
            r_scroll_x <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                default:      r_scroll_x <= i_cfg_data;
            endcase
        end
    end

    // timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_HBLANK;
            r_clock <= '0;
            r_line  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_clock <= n_clock;
            r_line  <= n_line;
        end
    end

    // mode stepping and command issue
    always_comb begin
        n_mode  = r_mode;
        n_clock = r_clock;
        n_line  = r_line;
        o_push  = 1'b0;
        o_cmd.kind = CMD_WRITE;
        o_cmd.addr = i_in.vram_address;
        o_cmd.data = i_in.vram_byte;
        o_cmd.col  = r_scroll_x[7:3];
        if (accept) begin
            if (i_in.mode == IN_WRITE) begin
                o_push = 1'b1;
            end else begin
                n_clock = clk_add;
                unique case (r_mode)
                    M_HBLANK: begin
                        if (clk_add >= HBLANK_CLOCKS) begin
                            n_clock    = '0;
                            n_line     = line_inc;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_LINE;
                            o_cmd.data = line_inc + 8'd1;
                            n_mode     = (line_inc == LAST_VIS_LINE) ? M_VBLANK : M_OAM;
                        end
                    end
                    M_VBLANK: begin
                        if (clk_add >= VBLANK_CLOCKS) begin
                            n_clock    = '0;
                            n_line     = line_inc;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_LINE;
                            o_cmd.data = line_inc + 8'd1;
                            if (line_inc > LAST_LINE) begin
                                n_mode = M_OAM;
                                n_line = '0;
                            end
                        end
                    end
                    M_OAM: begin
                        if (clk_add >= OAM_CLOCKS) begin
                            n_clock = '0;
                            n_mode  = M_XFER;
                        end
                    end
                    M_XFER: begin
                        if (clk_add >= XFER_CLOCKS) begin
                            n_clock    = '0;
                            n_mode     = M_HBLANK;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_FETCH;
                            o_cmd.data = r_line + r_scroll_y;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    `ASSERT_IMPLIES(a_vblank_lines, i_clk, i_rst_n, r_mode == M_VBLANK,
        r_line >= LAST_VIS_LINE && r_line <= LAST_LINE)
    `ASSERT_ALWAYS(a_clock_range, i_clk, i_rst_n, r_clock < VBLANK_CLOCKS)
    `ASSERT_IMPLIES(a_fetch_from_xfer, i_clk, i_rst_n, o_push && o_cmd.kind == CMD_FETCH,
        r_mode == M_XFER)

endmodule
`default_nettype wire

// ===== src/lmt_back.sv =====
// ----------------------------------------------------------------------------
// lmt_back
// video memory, clearing pass, line reports and background tile fetch
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lmt_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_empty,
    input  lmt_pkg::t_cmd         i_cmd,
    output logic                  o_pop,
    output lmt_pkg::t_back_status o_bstat,
    output logic                  o_valid,
    input  wire                   i_ready,
    output lmt_pkg::t_out         o_out
);
    import lmt_pkg::*;

    logic [7:0]         r_vram [VRAM_BYTES];
    logic [7:0]         r_rd_data;
    logic               rd_en, wr_en;
    logic [VRAM_AW-1:0] rd_addr, wr_addr;
    logic [7:0]         wr_data;

    logic               r_clr_busy;
    logic [VRAM_AW-1:0] r_clr_addr;

    t_bstate            r_state, n_state;
    logic [7:0]         r_row, n_row;
    logic [4:0]         r_col, n_col;
    logic [7:0]         r_tile, n_tile;
    logic [7:0]         r_lo, n_lo;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;
    logic               slot_free;

    assign o_bstat.clearing = r_clr_busy;
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;
    assign slot_free = !r_out_valid || i_ready;

    // video memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_vram[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_vram[rd_addr];
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_tile <= n_tile;
        r_lo   <= n_lo;
        r_out  <= n_out;
    end

    // command execution and tile fetch
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_tile      = r_tile;
        n_lo        = r_lo;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {MAP_BASE_HI, r_row[7:3], r_col};
        wr_en       = r_clr_busy;
        wr_addr     = r_clr_addr;
        wr_data     = '0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && !r_clr_busy) begin
                    unique case (i_cmd.kind)
                        CMD_WRITE: begin
                            o_pop   = 1'b1;
                            wr_en   = 1'b1;
                            wr_addr = i_cmd.addr;
                            wr_data = i_cmd.data;
                        end
                        CMD_LINE: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.kind  = OUT_LINE;
                                n_out.line_counter = i_cmd.data;
                                n_out.last  = 1'b1;
                            end
                        end
                        CMD_FETCH: begin
                            o_pop   = 1'b1;
                            n_row   = i_cmd.data;
                            n_col   = i_cmd.col;
                            n_state = B_MAP;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            B_MAP: begin
                rd_en   = 1'b1;
                n_state = B_TILE;
            end
            B_TILE: begin
                n_tile  = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = {1'b0, r_rd_data, r_row[2:0], 1'b0};
                n_state = B_LO;
            end
            B_LO: begin
                n_lo    = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = {1'b0, r_tile, r_row[2:0], 1'b1};
                n_state = B_HI;
            end
            B_HI: begin
                if (slot_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = OUT_PIX;
                    n_out.line_counter   = '0;
                    n_out.tile_column    = r_col;
                    n_out.background_row = r_row;
                    n_out.shades         = to_shades(r_lo, r_rd_data);
                    n_out.last           = (r_col == LAST_COLUMN);
                    n_col                = r_col + 5'd1;
                    n_state              = (r_col == LAST_COLUMN) ? B_IDLE : B_MAP;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    `ASSERT_IMPLIES(a_clear_quiet, i_clk, i_rst_n, r_clr_busy, !r_out_valid)
    `ASSERT_IMPLIES(a_clear_idle, i_clk, i_rst_n, r_clr_busy, r_state == B_IDLE)
    `ASSERT_IMPLIES(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == B_IDLE && !i_q_empty)

endmodule
`default_nettype wire

// ===== src/lcd_mode_timing_and_bg_line_fetch.sv =====
// LCD mode timing with background line fetch. The front takes one item per
// cycle (tick or video memory write) while the four-entry command queue has
// room. A line command gives one report from the back; a row fetch runs a
// map read, low plane, high plane and output for each tile, up to 32 tiles,
// bounded by the single video memory read port. After reset a clearing pass
// zeroes video memory, during which no item is accepted; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
// lcd_mode_timing_and_bg_line_fetch
// top level: timing front, command queue and fetch back
// ----------------------------------------------------------------------------
`default_nettype none
module lcd_mode_timing_and_bg_line_fetch (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  lmt_pkg::t_in  i_in,
    output logic          o_valid,
    input  wire           i_ready,
    output lmt_pkg::t_out o_out,
    input  wire           i_cfg_we,
    input  wire           i_cfg_idx,
    input  wire [7:0]     i_cfg_data
);
    import lmt_pkg::*;

    logic         push, pop, q_full, q_empty;
    t_cmd         push_cmd, pop_cmd;
    t_back_status bstat;

    // timing front
    lmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_bstat    (bstat),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // command queue
    lmt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (q_empty)
    );

    // fetch back
    lmt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_bstat   (bstat),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== test/lmt_checker.sv =====
// ----------------------------------------------------------------------------
// lmt_checker
// watches the item, result and register ports of the lcd timing block,
// predicts mode timing, line reports and background row fetches, and
// compares every result transfer with the oldest predicted result
// ----------------------------------------------------------------------------
`default_nettype none
module lmt_checker (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  wire           i_ready_in,
    input  lmt_pkg::t_in  i_in,
    input  wire           i_valid_out,
    input  wire           i_ready,
    input  lmt_pkg::t_out i_out,
    input  wire           i_cfg_we,
    input  wire           i_cfg_idx,
    input  wire [7:0]     i_cfg_data,
    output int            o_fail_count,
    output int            o_pending
);
    import lmt_pkg::*;

    // model copy of the block state
    t_lcd_mode   lcd_mode;
    logic [8:0]  mode_clock;
    logic [7:0]  line;
    logic [7:0]  scroll_y;
    logic [7:0]  scroll_x;
    logic [7:0]  vram [VRAM_BYTES];
    t_out        pixel_line_q[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pixel_line_q.size();

    function automatic logic [7:0] shade_of(input logic [1:0] code);
        case (code)
            2'd0:    return 8'd255;
            2'd1:    return 8'd192;
            2'd2:    return 8'd96;
            default: return 8'd0;
        endcase
    endfunction

    // line register report after the line has advanced
    function automatic void push_line_report();
        t_out r;
        r = '0;
        r.kind = OUT_LINE;
        r.line_counter = line + 8'd1;
        r.last = 1'b1;
        pixel_line_q.push_back(r);
    endfunction

    // one background row, from the first scrolled tile column to column 31
    function automatic void fetch_row();
        logic [7:0]  row;
        logic [7:0]  tile;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [63:0] pix;
        t_out        r;
        row = line + scroll_y;
        for (int col = int'(scroll_x >> 3); col < 32; col++) begin
            tile = vram[{3'b110, row[7:3], 5'(col)}];
            lo = vram[{1'b0, tile, row[2:0], 1'b0}];
            hi = vram[{1'b0, tile, row[2:0], 1'b1}];
            pix = '0;
            for (int b = 7; b >= 0; b--)
                pix = {pix[55:0], shade_of({hi[b], lo[b]})};
            r = '0;
            r.kind = OUT_PIX;
            r.tile_column = 5'(col);
            r.background_row = row;
            r.shades = pix;
            r.last = (col == 31);
            pixel_line_q.push_back(r);
        end
    endfunction

    function automatic void advance(input t_in x);
        if (x.mode == IN_WRITE) begin
            vram[x.vram_address] = x.vram_byte;
            return;
        end
        mode_clock = mode_clock + TICK_CLOCKS;
        case (lcd_mode)
            M_HBLANK: if (mode_clock >= HBLANK_CLOCKS) begin
                mode_clock = '0;
                line = line + 8'd1;
                push_line_report();
                lcd_mode = (line == LAST_VIS_LINE) ? M_VBLANK : M_OAM;
            end
            M_VBLANK: if (mode_clock >= VBLANK_CLOCKS) begin
                mode_clock = '0;
                line = line + 8'd1;
                push_line_report();
                // leaving vblank: back to the top of the frame
                if (line > LAST_LINE) begin
                    lcd_mode = M_OAM;
                    line = '0;
                end
            end
            M_OAM: if (mode_clock >= OAM_CLOCKS) begin
                mode_clock = '0;
                lcd_mode = M_XFER;
            end
            default: if (mode_clock >= XFER_CLOCKS) begin
                mode_clock = '0;
                lcd_mode = M_HBLANK;
                fetch_row();
            end
        endcase
    endfunction

    // watch transfers and register writes
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            lcd_mode = M_HBLANK;
            mode_clock = '0;
            line = '0;
            scroll_y = '0;
            scroll_x = '0;
            for (int a = 0; a < VRAM_BYTES; a++)
                vram[a] = '0;
            pixel_line_q.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SCROLL_Y)
                    scroll_y = i_cfg_data;
                else
                    scroll_x = i_cfg_data;
            end
            if (i_valid_out && i_ready) begin
                if (pixel_line_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result transfer %h", i_out);
                end else begin
                    e = pixel_line_q.pop_front();
                    if (i_out.kind !== e.kind || i_out.line_counter !== e.line_counter
                            || i_out.tile_column !== e.tile_column
                            || i_out.background_row !== e.background_row
                            || i_out.shades !== e.shades || i_out.last !== e.last) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("mismatch (exp/act): kind %0d/%0d line %0d/%0d",
                                     e.kind, i_out.kind, e.line_counter, i_out.line_counter);
                            $display("  col %0d/%0d row %0d/%0d shades %h/%h last %0d/%0d",
                                     e.tile_column, i_out.tile_column, e.background_row,
                                     i_out.background_row, e.shades, i_out.shades,
                                     e.last, i_out.last);
                        end
                    end
                end
            end
            if (i_valid && i_ready_in)
                advance(i_in);
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_lcd_mode_timing_and_bg_line_fetch.sv =====
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_and_bg_line_fetch
// drives ticks and video memory writes over several lines under several
// scroll settings with random gaps and stalls; the checker judges results
// ----------------------------------------------------------------------------
`default_nettype none
module tb_lcd_mode_timing_and_bg_line_fetch;
    import lmt_pkg::*;

    localparam int IDLE_LIMIT  = 40000;
    localparam int DRAIN_WAIT  = 200;
    localparam int PHASE_ITEMS = 55;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_in;
    logic o_valid;
    logic i_ready;
    t_out o_out;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic no_gaps;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    lcd_mode_timing_and_bg_line_fetch u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    lmt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_in(i_in),
        .i_valid_out(o_valid), .i_ready(i_ready), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one item transfer after a random gap
    task automatic send(input t_in x);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic vram_write(input logic [12:0] addr, input logic [7:0] data);
        t_in x;
        x.mode = IN_WRITE;
        x.vram_address = addr;
        x.vram_byte = data;
        send(x);
    endtask

    task automatic tick();
        t_in x;
        x.mode = IN_TICK;
        x.vram_address = 13'($urandom);
        x.vram_byte = 8'($urandom);
        send(x);
    endtask

    // let the block drain before touching the scroll registers
    task automatic set_scroll(input logic [7:0] sy, input logic [7:0] sx);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SCROLL_Y;
        i_cfg_data <= sy;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SCROLL_X;
        i_cfg_data <= sx;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result side stalls
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("lcd_mode_timing_and_bg_line_fetch regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        logic [7:0] sy;
        logic [7:0] sx;
        int pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SCROLL_Y;
        i_cfg_data = '0;
        no_gaps = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: address extremes, a plain tile and tile 255 at the map edge
        vram_write(13'h0000, 8'h0F);
        vram_write(13'h0001, 8'h33);
        vram_write(13'h0002, 8'hFF);
        vram_write(13'h0003, 8'h00);
        vram_write(13'h1FFF, 8'hFF);
        vram_write(13'h1800 + 13'd31, 8'hFF);
        vram_write(13'h1820 + 13'd31, 8'hFF);
        vram_write(13'h0FF0, 8'hA5);
        vram_write(13'h0FF1, 8'h3C);
        vram_write(13'h0FF2, 8'h00);
        vram_write(13'h0FF3, 8'hFF);
        vram_write(13'h1BFF, 8'h80);
        vram_write(13'h1800, 8'h00);

        // random phases over several scroll settings, a few lines in all
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin sy = 8'd0;   sx = 8'd0;   end
                1: begin sy = 8'd255; sx = 8'd255; end
                2: begin sy = 8'd0;   sx = 8'd255; end
                3: begin sy = 8'd255; sx = 8'd0;   end
                4: begin sy = 8'hAA;  sx = 8'h55;  end
                5: begin sy = 8'h55;  sx = 8'hAA;  end
                default: begin sy = 8'($urandom); sx = 8'($urandom); end
            endcase
            set_scroll(sy, sx);
            no_gaps = (ph % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    tick();
                else if (pick < 92)
                    vram_write(13'h1800 + 13'($urandom_range(0, 1023)), 8'($urandom));
                else if (pick < 97)
                    vram_write(13'($urandom_range(0, 4095)), 8'($urandom));
                else
                    vram_write(13'($urandom), 8'($urandom));
            end
        end
        no_gaps = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("lcd_mode_timing_and_bg_line_fetch regression: pass");
        else
            $display("lcd_mode_timing_and_bg_line_fetch regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
